// File: design/lprt_pkg.sv
// Package: shared constants, types and the hash for the linear probe request table.
`timescale 1ns / 1ps
`default_nettype none
package lprt_pkg;

	// Slot count; keep it a power of two so the home slot is a mask of the folded handle.
	localparam int TABLE_ENTRIES = 4096;
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int HASH_SHIFT_LO = 16;
	localparam int HASH_SHIFT_HI = 32;
	localparam int HANDLE_W      = 64;
	localparam int BYTES_W       = 64;
	localparam int KIND_W        = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 4;

	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_TAKE  = 1'b1;

	// Register 0 (null handle) lives at byte address 0; address bit 3 selects the index.
	localparam logic REG_NULL_HANDLE = 1'b0;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic                func;
		logic                is_null;
		logic [HANDLE_W-1:0] handle;
		logic [KIND_W-1:0]   kind;
		logic [BYTES_W-1:0]  bytes;
		slot_t               home;
	} cmd_t;

	typedef struct packed {
		logic                valid;
		logic [HANDLE_W-1:0] key;
		logic [KIND_W-1:0]   kind;
		logic [BYTES_W-1:0]  bytes;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} back_state_t;

	function automatic slot_t home_slot(input logic [HANDLE_W-1:0] h);
		logic [HANDLE_W-1:0] folded;
		folded = h ^ (h >> HASH_SHIFT_LO) ^ (h >> HASH_SHIFT_HI);
		return folded[SLOT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: design/lprt_req_if.sv
// Interface: request channel carrying one store or take item.
`timescale 1ns / 1ps
`default_nettype none
interface lprt_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] request_handle;
	logic [1:0]  entry_kind;
	logic [63:0] byte_count;

	modport source (
		output valid, func, request_handle, entry_kind, byte_count,
		input  ready
	);
	modport sink (
		input  valid, func, request_handle, entry_kind, byte_count,
		output ready
	);
endinterface
`default_nettype wire

// File: design/lprt_rsp_if.sv
// Interface: response channel carrying one result item.
`timescale 1ns / 1ps
`default_nettype none
interface lprt_rsp_if;
	logic        valid;
	logic        ready;
	logic        success;
	logic [1:0]  found_kind;
	logic [63:0] found_bytes;

	modport source (
		output valid, success, found_kind, found_bytes,
		input  ready
	);
	modport sink (
		input  valid, success, found_kind, found_bytes,
		output ready
	);
endinterface
`default_nettype wire

// File: design/lprt_front.sv
// Front end: accept request transfers, flag null handles and compute the home slot.
`timescale 1ns / 1ps
`default_nettype none
module lprt_front
	import lprt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lprt_req_if.sink                   req,
	input  wire logic [HANDLE_W-1:0]   null_handle,
	input  wire logic                  clearing,
	output logic                       push_valid,
	output cmd_t                       push_cmd,
	input  wire logic                  push_ready
);

	logic v_s1;
	cmd_t cmd_s1;
	logic accept;

	assign req.ready  = !clearing && (!v_s1 || push_ready);
	assign accept     = req.valid && req.ready;
	assign push_valid = v_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.func    <= req.func;
			cmd_s1.is_null <= (req.request_handle == null_handle);
			cmd_s1.handle  <= req.request_handle;
			cmd_s1.kind    <= req.entry_kind;
			cmd_s1.bytes   <= req.byte_count;
			cmd_s1.home    <= home_slot(req.request_handle);
		end
	end

endmodule
`default_nettype wire

// File: design/lprt_queue.sv
// Command queue: short FIFO between the front end and the probe engine.
`timescale 1ns / 1ps
`default_nettype none
module lprt_queue
	import lprt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	input  wire cmd_t push_cmd,
	output logic      push_ready,
	output logic      pop_valid,
	output cmd_t      pop_cmd,
	input  wire logic pop
);

	cmd_t                   buf_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = buf_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: design/lprt_back.sv
// Probe engine: slot memory, clearing sweep, linear probe sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module lprt_back
	import lprt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      clearing,
	lprt_rsp_if.source rsp
);

	localparam slot_t LAST_SLOT = slot_t'(TABLE_ENTRIES - 1);

	entry_t      mem [TABLE_ENTRIES];
	entry_t      rd_q;
	back_state_t state_q, state_d;
	slot_t       clr_q;
	slot_t       pos_q, pos_d;
	slot_t       n_q, n_d;
	cmd_t        op_q;

	logic                out_v_q;
	logic                out_success_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [BYTES_W-1:0]  out_bytes_q;

	logic                rd_en;
	slot_t               rd_addr;
	logic                wr_en;
	slot_t               wr_addr;
	entry_t              wr_data;
	logic                res_load;
	logic                res_success;
	logic [KIND_W-1:0]   res_kind;
	logic [BYTES_W-1:0]  res_bytes;
	logic                out_free;
	logic                key_hit;

	assign clearing        = (state_q == ST_CLEAR);
	assign out_free        = !out_v_q || rsp.ready;
	assign key_hit         = rd_q.valid && (rd_q.key == op_q.handle);
	assign rsp.valid       = out_v_q;
	assign rsp.success     = out_success_q;
	assign rsp.found_kind  = out_kind_q;
	assign rsp.found_bytes = out_bytes_q;

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		n_d         = n_q;
		rd_en       = 1'b0;
		rd_addr     = pos_q;
		wr_en       = 1'b0;
		wr_addr     = pos_q;
		wr_data     = '{valid: 1'b1, key: op_q.handle, kind: op_q.kind, bytes: op_q.bytes};
		cmd_pop     = 1'b0;
		res_load    = 1'b0;
		res_success = 1'b0;
		res_kind    = '0;
		res_bytes   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en         = 1'b1;
				wr_addr       = clr_q;
				wr_data.valid = 1'b0;
				if (clr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (cmd.is_null) begin
						res_load = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = cmd.home;
						pos_d   = cmd.home;
						n_d     = '0;
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				priority if (op_q.func == FUNC_STORE && (!rd_q.valid || key_hit)) begin
					wr_en       = 1'b1;
					res_load    = 1'b1;
					res_success = 1'b1;
					state_d     = ST_IDLE;
				end else if (op_q.func == FUNC_TAKE && !rd_q.valid) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else if (op_q.func == FUNC_TAKE && key_hit) begin
					// Free the slot; no tombstone is left behind.
					wr_en         = 1'b1;
					wr_data.valid = 1'b0;
					res_load      = 1'b1;
					res_success   = 1'b1;
					res_kind      = rd_q.kind;
					res_bytes     = rd_q.bytes;
					state_d       = ST_IDLE;
				end else if (n_q == LAST_SLOT) begin
					// Every slot visited: store dropped or take missed.
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					pos_d   = pos_q + 1'b1;
					n_d     = n_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = pos_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		n_q   <= n_d;
		if (cmd_pop) begin
			op_q <= cmd;
		end
		if (res_load) begin
			out_success_q <= res_success;
			out_kind_q    <= res_kind;
			out_bytes_q   <= res_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: design/linear_probe_request_table_top.sv
// Top level: request table with APB register port, front end, command queue and probe engine.
//
// Usage:
//   req carries store (func 0) and take (func 1) transfers with a 64-bit handle, a kind and a
//   byte count; rsp returns exactly one result transfer per request, in request order.
//   The APB port holds one 64-bit register at byte address 0: the null handle. A request
//   with that handle leaves the table untouched and returns an all-zero result. Write it
//   only while no request is in flight.
// Flow:
//   Each request passes the front register and the queue; when idle with a free result
//   register, the engine pops the queue head in the cycle it lands and issues the home-slot
//   read, probes one slot per cycle (registered read data), and loads the result register.
//   It takes one request at a time, probing at most TABLE_ENTRIES slots before it answers.
// Reset:
//   arst_n clears control state, sets the null handle to 0 and starts a clearing sweep that
//   invalidates one slot per cycle over all TABLE_ENTRIES (4096) slots; req.ready stays low
//   meanwhile, while register writes are taken as usual.
// Backpressure:
//   When rsp stalls, the engine holds its finished result and waits; the front register and
//   the two-entry queue keep taking requests until they fill.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_request_table_top
	import lprt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	lprt_req_if.sink                   req,
	lprt_rsp_if.source                 rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [HANDLE_W-1:0] null_handle_q;
	logic                clearing;
	logic                push_valid;
	cmd_t                push_cmd;
	logic                push_ready;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_pop;
	logic                reg_sel;

	// Address bit 3 picks the 64-bit register; anything past the list reads as zero.
	assign reg_sel = (paddr[3] == REG_NULL_HANDLE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? null_handle_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_handle_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			null_handle_q <= pwdata;
		end
	end

	lprt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.null_handle (null_handle_q),
		.clearing    (clearing),
		.push_valid  (push_valid),
		.push_cmd    (push_cmd),
		.push_ready  (push_ready)
	);

	lprt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (cmd_valid),
		.pop_cmd    (cmd),
		.pop        (cmd_pop)
	);

	lprt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
